// ===== sv/mufp_pkg.sv =====
// package for the multicast udp packet filter
// verdict codes, frame layout offsets, register indexes and the frame summary type
// no dependencies
package mufp_pkg;

   // verdict codes
   localparam logic [1:0] VERDICT_PASS     = 2'd0;
   localparam logic [1:0] VERDICT_REDIRECT = 2'd1;
   localparam logic [1:0] VERDICT_DROP     = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ENABLED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_GROUP   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_PORT    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_MASK     = 2'd3;

   // default queue count and queue index width
   localparam int QUEUE_COUNT_DEFAULT = 64;
   localparam int QUEUE_INDEX_W       = 6;

   // frame layout, offsets from the destination mac
   localparam int OFFSET_W = 7;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX        = 7'd127;
   localparam logic [OFFSET_W-1:0] OFF_ETHERTYPE_HI  = 7'd12;
   localparam logic [OFFSET_W-1:0] OFF_ETHERTYPE_LO  = 7'd13;
   localparam logic [OFFSET_W-1:0] OFF_IHL           = 7'd14;
   localparam logic [OFFSET_W-1:0] OFF_PROTOCOL      = 7'd23;
   localparam logic [OFFSET_W-1:0] OFF_DEST_FIRST    = 7'd30;
   localparam logic [OFFSET_W-1:0] OFF_DEST_LAST     = 7'd33;
   // udp destination port sits at 14 + 4*ihl + 2
   localparam logic [OFFSET_W-1:0] OFF_PORT_BASE     = 7'd16;
   // last offset below which a frame is too short for each header
   localparam logic [OFFSET_W-1:0] OFF_MIN_ETH_LAST  = 7'd13;
   localparam logic [OFFSET_W-1:0] OFF_MIN_IP_LAST   = 7'd33;
   // ethernet header plus udp header, minus one for the last offset
   localparam logic [OFFSET_W-1:0] OFF_MIN_UDP_BASE  = 7'd21;

   // header field values
   localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
   localparam logic [7:0]  PROTOCOL_UDP     = 8'd17;
   localparam logic [31:0] MCAST_MASK       = 32'hF000_0000;
   localparam logic [31:0] MCAST_PREFIX     = 32'hE000_0000;
   localparam logic [3:0]  IHL_MIN          = 4'd5;

   // queue between front and back
   localparam int SUMMARY_QUEUE_DEPTH = 2;

   // per-frame summary handed from front to back
   typedef struct packed {
      logic                     frame_ok;
      logic [31:0]              destination;
      logic [15:0]              udp_port;
      logic [QUEUE_INDEX_W-1:0] queue_index;
   } frame_summary_type;

   // queue fill status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== sv/mufp_if.sv =====
// channel interfaces for the multicast udp packet filter
// request carries frame bytes, response carries verdicts; uses mufp_pkg
interface mufp_req_if;
   logic                               valid;
   logic                               ready;
   logic [7:0]                         packet_byte;
   logic                               last_byte;
   logic [mufp_pkg::QUEUE_INDEX_W-1:0] queue_index;

   modport source (output valid, output packet_byte, output last_byte, output queue_index,
                   input ready);
   modport sink   (input valid, input packet_byte, input last_byte, input queue_index,
                   output ready);
endinterface

interface mufp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         verdict;
   logic [mufp_pkg::QUEUE_INDEX_W-1:0] target_queue;

   modport source (output valid, output verdict, output target_queue, input ready);
   modport sink   (input valid, input verdict, input target_queue, output ready);
endinterface

// ===== sv/mufp_front.sv =====
// front end: tracks the byte offset, captures header fields, summarizes each frame
// depends on mufp_pkg
module mufp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               beat_accept,
   input  logic [7:0]                         packet_byte,
   input  logic                               last_byte,
   input  logic [mufp_pkg::QUEUE_INDEX_W-1:0] queue_index,
   output logic                               summary_push,
   output mufp_pkg::frame_summary_type        summary
);

   logic [mufp_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [15:0]                   ethertype_ff, ethertype_in;
   logic [3:0]                    header_words_ff, header_words_in;
   logic [7:0]                    protocol_ff, protocol_in;
   logic [31:0]                   destination_ff, destination_in;
   logic [15:0]                   port_ff, port_in;
   logic [mufp_pkg::OFFSET_W-1:0] port_at;
   logic [mufp_pkg::OFFSET_W-1:0] udp_min_last;
   logic                          long_enough;
   logic                          type_ok;

   // field capture at the current offset
   always_comb begin
      port_at = mufp_pkg::OFF_PORT_BASE + {1'b0, header_words_ff, 2'b00};

      ethertype_in = ethertype_ff;
      if (offset_ff == mufp_pkg::OFF_ETHERTYPE_HI || offset_ff == mufp_pkg::OFF_ETHERTYPE_LO) begin
         ethertype_in = {ethertype_ff[7:0], packet_byte};
      end

      header_words_in = header_words_ff;
      if (offset_ff == mufp_pkg::OFF_IHL) begin
         header_words_in = packet_byte[3:0];
      end

      protocol_in = protocol_ff;
      if (offset_ff == mufp_pkg::OFF_PROTOCOL) begin
         protocol_in = packet_byte;
      end

      destination_in = destination_ff;
      if (offset_ff >= mufp_pkg::OFF_DEST_FIRST && offset_ff <= mufp_pkg::OFF_DEST_LAST) begin
         destination_in = {destination_ff[23:0], packet_byte};
      end

      port_in = port_ff;
      if (offset_ff == port_at || offset_ff == port_at + 7'd1) begin
         port_in = {port_ff[7:0], packet_byte};
      end

      offset_in = offset_ff;
      if (offset_ff != mufp_pkg::OFFSET_MAX) begin
         offset_in = offset_ff + 7'd1;
      end
   end

   // structural checks on the completed frame
   always_comb begin
      udp_min_last = mufp_pkg::OFF_MIN_UDP_BASE + {1'b0, header_words_in, 2'b00};
      long_enough  = (offset_ff >= mufp_pkg::OFF_MIN_ETH_LAST)
                  && (offset_ff >= mufp_pkg::OFF_MIN_IP_LAST)
                  && (offset_ff >= udp_min_last);
      type_ok      = (ethertype_in == mufp_pkg::ETHERTYPE_IPV4)
                  && (protocol_in == mufp_pkg::PROTOCOL_UDP)
                  && ((destination_in & mufp_pkg::MCAST_MASK) == mufp_pkg::MCAST_PREFIX)
                  && (header_words_in >= mufp_pkg::IHL_MIN);

      summary.frame_ok    = long_enough && type_ok;
      summary.destination = destination_in;
      summary.udp_port    = port_in;
      summary.queue_index = queue_index;
      summary_push        = beat_accept && last_byte;
   end

   // capture state, cleared after the last beat of a frame
   always_ff @(posedge clock) begin
      if (reset || (beat_accept && last_byte)) begin
         offset_ff       <= '0;
         ethertype_ff    <= '0;
         header_words_ff <= '0;
         protocol_ff     <= '0;
         destination_ff  <= '0;
         port_ff         <= '0;
      end else if (beat_accept) begin
         offset_ff       <= offset_in;
         ethertype_ff    <= ethertype_in;
         header_words_ff <= header_words_in;
         protocol_ff     <= protocol_in;
         destination_ff  <= destination_in;
         port_ff         <= port_in;
      end
   end

endmodule

// ===== sv/mufp_queue.sv =====
// short queue of frame summaries between front and back
// depends on mufp_pkg
module mufp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mufp_pkg::frame_summary_type push_data,
   input  logic                        pop,
   output mufp_pkg::frame_summary_type pop_data,
   output mufp_pkg::queue_status_type  status
);

   localparam int DEPTH = mufp_pkg::SUMMARY_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mufp_pkg::frame_summary_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // status and pointer updates
   always_comb begin
      status.full  = (count_ff == CNT_W'(DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      pop_data     = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/mufp_back.sv =====
// back end: holds the filter registers, matches summaries, registers the verdict
// depends on mufp_pkg
module mufp_back #(
   parameter int QUEUE_COUNT = mufp_pkg::QUEUE_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [mufp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mufp_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  mufp_pkg::queue_status_type          queue_status,
   input  mufp_pkg::frame_summary_type         summary,
   output logic                                summary_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_verdict,
   output logic [mufp_pkg::QUEUE_INDEX_W-1:0]  rsp_target_queue
);

   localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

   logic                                filter_enabled_ff;
   logic [31:0]                         target_group_ff;
   logic [15:0]                         match_port_ff;
   logic [QUEUE_COUNT-1:0]              queue_mask_ff;
   logic                                out_valid_ff, out_valid_in;
   logic [1:0]                          verdict_ff, verdict_in;
   logic [mufp_pkg::QUEUE_INDEX_W-1:0]  target_queue_ff, target_queue_in;
   logic                                flow_match;
   logic                                queue_in_range;
   logic                                socket_present;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enabled_ff <= 1'b0;
         target_group_ff   <= '0;
         match_port_ff     <= '0;
         queue_mask_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mufp_pkg::CSR_FILTER_ENABLED: filter_enabled_ff <= csr_write_data[0];
            mufp_pkg::CSR_TARGET_GROUP:   target_group_ff   <= csr_write_data[31:0];
            mufp_pkg::CSR_TARGET_PORT:    match_port_ff     <= csr_write_data[15:0];
            mufp_pkg::CSR_QUEUE_MASK:     queue_mask_ff     <= csr_write_data[QUEUE_COUNT-1:0];
            default: ;
         endcase
      end
   end

   // match the summary at the head of the queue
   always_comb begin
      summary_pop    = !queue_status.empty && (!out_valid_ff || rsp_ready);
      flow_match     = filter_enabled_ff && summary.frame_ok
                    && (summary.destination == target_group_ff)
                    && (summary.udp_port == match_port_ff);
      queue_in_range = ({1'b0, summary.queue_index} < (mufp_pkg::QUEUE_INDEX_W + 1)'(QUEUE_COUNT));
      socket_present = queue_in_range && queue_mask_ff[summary.queue_index[QIDX_W-1:0]];

      verdict_in      = mufp_pkg::VERDICT_PASS;
      target_queue_in = '0;
      if (flow_match && socket_present) begin
         verdict_in      = mufp_pkg::VERDICT_REDIRECT;
         target_queue_in = summary.queue_index;
      end else if (flow_match) begin
         verdict_in      = mufp_pkg::VERDICT_DROP;
      end

      out_valid_in = out_valid_ff;
      if (summary_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (summary_pop) begin
         verdict_ff      <= verdict_in;
         target_queue_ff <= target_queue_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_target_queue = target_queue_ff;

endmodule

// ===== sv/multicast_udp_packet_filter.sv =====
// top level of the multicast udp packet filter
// depends on mufp_pkg, mufp_if, mufp_front, mufp_queue, mufp_back
//
//   channel   direction  carries
//   req_ch    in         packet_byte, last_byte, queue_index (one frame byte per beat)
//   rsp_ch    out        verdict, target_queue (one beat per frame, on its last byte)
//   csr_*     in         write enable, register index, 64-bit write data
//
// one request beat per cycle while the summary queue has room; the verdict passes through
// the summary queue and then the output register once the last byte is accepted.
// a two-entry summary queue lets bytes keep flowing while a verdict waits on rsp_ch;
// req_ch stalls only when that queue is full.
// reset is synchronous and clears the capture state, queue and filter registers.
module multicast_udp_packet_filter #(
   parameter int QUEUE_COUNT = mufp_pkg::QUEUE_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   mufp_req_if.sink                         req_ch,
   mufp_rsp_if.source                       rsp_ch,
   input  logic                             csr_write_enable,
   input  logic [mufp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mufp_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic                        beat_accept;
   logic                        summary_push;
   logic                        summary_pop;
   mufp_pkg::frame_summary_type push_summary;
   mufp_pkg::frame_summary_type head_summary;
   mufp_pkg::queue_status_type  queue_status;

   // accept bytes while the summary queue has room
   assign req_ch.ready = !queue_status.full;
   assign beat_accept  = req_ch.valid && req_ch.ready;

   mufp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .beat_accept  (beat_accept),
      .packet_byte  (req_ch.packet_byte),
      .last_byte    (req_ch.last_byte),
      .queue_index  (req_ch.queue_index),
      .summary_push (summary_push),
      .summary      (push_summary)
   );

   mufp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (summary_push),
      .push_data (push_summary),
      .pop       (summary_pop),
      .pop_data  (head_summary),
      .status    (queue_status)
   );

   mufp_back #(
      .QUEUE_COUNT (QUEUE_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .summary          (head_summary),
      .summary_pop      (summary_pop),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_verdict      (rsp_ch.verdict),
      .rsp_target_queue (rsp_ch.target_queue)
   );

   // a summary is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) !(summary_push && queue_status.full))
      else $error("summary pushed into full queue");

   // verdict codes stay within pass, redirect and drop
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.verdict == mufp_pkg::VERDICT_PASS
                     || rsp_ch.verdict == mufp_pkg::VERDICT_REDIRECT
                     || rsp_ch.verdict == mufp_pkg::VERDICT_DROP))
      else $error("undefined verdict code");

   // only a redirect names a queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.verdict != mufp_pkg::VERDICT_REDIRECT) |-> rsp_ch.target_queue == '0)
      else $error("target queue set without redirect");

   // a verdict is loaded only from a queued summary
   assert property (@(posedge clock) disable iff (reset)
      summary_pop |-> !queue_status.empty)
      else $error("pop from empty summary queue");

endmodule
